/* design/lncs_pkg.sv */
`timescale 1ns / 1ps

package lncs_pkg;

	// request op codes
	localparam logic [2:0] OP_INIT  = 3'd0;
	localparam logic [2:0] OP_CLEAR = 3'd1;
	localparam logic [2:0] OP_CHAR  = 3'd2;
	localparam logic [2:0] OP_NUM2  = 3'd3;
	localparam logic [2:0] OP_NUM4  = 3'd4;

	typedef enum logic [2:0] {
		KIND_INIT  = 3'd0,
		KIND_CLEAR = 3'd1,
		KIND_CHAR  = 3'd2,
		KIND_NUM2  = 3'd3,
		KIND_NUM4  = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [13:0] value;
	} in_word_t;

	typedef struct packed {
		logic       rs;
		logic [3:0] nibble;
		logic       last;
	} out_word_t;

	// classified request: char byte in data[7:0], or BCD digits {th, h, t, o}
	typedef struct packed {
		kind_t       kind;
		logic [15:0] data;
	} entry_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [13:0] NUM2_MAX = 14'd99;
	localparam logic [13:0] NUM4_MAX = 14'd9999;
	localparam logic [13:0] DEC_W3   = 14'd1000;
	localparam logic [13:0] DEC_W2   = 14'd100;
	localparam logic [13:0] DEC_W1   = 14'd10;
	localparam logic [7:0]  ASCII_ZERO = 8'd48;

	// power-up: 3,3,3,2 then 0x2C, 0x08, 0x01, 0x06, 0x0F as nibble pairs
	localparam logic [3:0] INIT_NIBBLES [16] = '{
		4'h3, 4'h3, 4'h3, 4'h2,
		4'h2, 4'hC, 4'h0, 4'h8,
		4'h0, 4'h1, 4'h0, 4'h6,
		4'h0, 4'hF, 4'h0, 4'h0
	};

	// clear display, then entry mode
	localparam logic [3:0] CLEAR_NIBBLES [4] = '{4'h0, 4'h1, 4'h0, 4'h6};

	// decimal digit of v for weight w (v < 10*w): count of thresholds passed
	function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [13:0] w);
		logic [3:0]  d;
		logic [17:0] thr;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			thr = 18'(k) * {4'b0, w};
			if ({4'b0, v} >= thr)
				d = 4'(k);
		end
		return d;
	endfunction

	// index of the final nibble of a request
	function automatic logic [3:0] seq_last(input kind_t kind);
		logic [3:0] n;
		unique case (kind)
			KIND_INIT:  n = 4'd13;
			KIND_CLEAR: n = 4'd3;
			KIND_CHAR:  n = 4'd1;
			KIND_NUM2:  n = 4'd3;
			KIND_NUM4:  n = 4'd7;
			default:    n = 4'd0;
		endcase
		return n;
	endfunction

	// {rs, nibble} for step idx of a request
	function automatic logic [4:0] step_nibble(input kind_t kind, input logic [15:0] data,
			input logic [3:0] idx);
		logic [3:0] dig;
		logic [7:0] chr;
		logic [4:0] r;
		dig = '0;
		chr = data[7:0];
		unique case (kind)
			KIND_NUM2: begin
				dig = idx[1] ? data[3:0] : data[7:4];
				chr = ASCII_ZERO + {4'b0, dig};
			end
			KIND_NUM4: begin
				unique case (idx[2:1])
					2'd0:    dig = data[15:12];
					2'd1:    dig = data[11:8];
					2'd2:    dig = data[7:4];
					default: dig = data[3:0];
				endcase
				chr = ASCII_ZERO + {4'b0, dig};
			end
			default: chr = data[7:0];
		endcase
		unique case (kind)
			KIND_INIT:  r = {1'b0, INIT_NIBBLES[idx]};
			KIND_CLEAR: r = {1'b0, CLEAR_NIBBLES[idx[1:0]]};
			KIND_CHAR, KIND_NUM2, KIND_NUM4:
				r = {1'b1, idx[0] ? chr[3:0] : chr[7:4]};
			default:    r = '0;
		endcase
		return r;
	endfunction

endpackage

/* design/lncs_front.sv */
`timescale 1ns / 1ps

// Classify requests and split numbers into decimal digits: thousands, then hundreds, then tens and ones.
module lncs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  lncs_pkg::in_word_t in_word,
	output logic               q_wr,
	output lncs_pkg::entry_t   q_wr_data,
	input  logic               q_full
);

	logic adv;
	logic op_ok;
	lncs_pkg::kind_t kind_d;
	logic [13:0] num_d;
	logic [3:0]  th_d;
	logic [3:0]  h_d;
	logic [3:0]  t_d;

	logic v1_q, v2_q, v3_q;
	lncs_pkg::kind_t kind_s1, kind_s2, kind_s3;
	logic [7:0]  chr_s1, chr_s2;
	logic [3:0]  th_s1, th_s2;
	logic [9:0]  rem_s1;
	logic [3:0]  h_s2;
	logic [6:0]  rem_s2;
	logic [15:0] data_s3;

	// whole pipe holds while its output cannot enter the queue
	assign adv  = !(v3_q && q_full);
	assign full = !adv;

	always_comb begin
		op_ok  = 1'b1;
		kind_d = lncs_pkg::KIND_INIT;
		unique case (in_word.op)
			lncs_pkg::OP_INIT:  kind_d = lncs_pkg::KIND_INIT;
			lncs_pkg::OP_CLEAR: kind_d = lncs_pkg::KIND_CLEAR;
			lncs_pkg::OP_CHAR:  kind_d = lncs_pkg::KIND_CHAR;
			lncs_pkg::OP_NUM2:  kind_d = lncs_pkg::KIND_NUM2;
			lncs_pkg::OP_NUM4:  kind_d = lncs_pkg::KIND_NUM4;
			default:            op_ok  = 1'b0;   // unused codes are dropped
		endcase
	end

	always_comb begin
		if (in_word.op == lncs_pkg::OP_NUM2)
			num_d = (in_word.value > lncs_pkg::NUM2_MAX) ? lncs_pkg::NUM2_MAX : in_word.value;
		else
			num_d = (in_word.value > lncs_pkg::NUM4_MAX) ? lncs_pkg::NUM4_MAX : in_word.value;
		th_d = lncs_pkg::dec_digit(num_d, lncs_pkg::DEC_W3);
	end

	assign h_d = lncs_pkg::dec_digit({4'b0, rem_s1}, lncs_pkg::DEC_W2);
	assign t_d = lncs_pkg::dec_digit({7'b0, rem_s2}, lncs_pkg::DEC_W1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else if (adv) begin
			v1_q <= push && op_ok;
			v2_q <= v1_q;
			v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= kind_d;
			chr_s1  <= in_word.value[7:0];
			th_s1   <= th_d;
			rem_s1  <= 10'(num_d - 14'(th_d) * lncs_pkg::DEC_W3);

			kind_s2 <= kind_s1;
			chr_s2  <= chr_s1;
			th_s2   <= th_s1;
			h_s2    <= h_d;
			rem_s2  <= 7'({4'b0, rem_s1} - 14'(h_d) * lncs_pkg::DEC_W2);

			kind_s3 <= kind_s2;
			if (kind_s2 == lncs_pkg::KIND_CHAR)
				data_s3 <= {8'b0, chr_s2};
			else
				data_s3 <= {th_s2, h_s2, t_d,
					4'({7'b0, rem_s2} - 14'(t_d) * lncs_pkg::DEC_W1)};
		end
	end

	assign q_wr           = v3_q && !q_full;
	assign q_wr_data.kind = kind_s3;
	assign q_wr_data.data = data_s3;

endmodule

/* design/lncs_queue.sv */
`timescale 1ns / 1ps

// Small FIFO of classified requests between front and back.
module lncs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  lncs_pkg::entry_t wr_data,
	output logic             full,
	input  logic             rd,
	output lncs_pkg::entry_t rd_data,
	output logic             nonempty
);

	lncs_pkg::entry_t mem_q [lncs_pkg::QUEUE_DEPTH];
	logic [lncs_pkg::QUEUE_AW-1:0] wp_q, rp_q;
	logic [lncs_pkg::QUEUE_CW-1:0] cnt_q;

	assign full     = cnt_q == lncs_pkg::QUEUE_CW'(lncs_pkg::QUEUE_DEPTH);
	assign nonempty = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == lncs_pkg::QUEUE_AW'(lncs_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == lncs_pkg::QUEUE_AW'(lncs_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end

endmodule

/* design/lncs_back.sv */
`timescale 1ns / 1ps

// Nibble sequencer: walks one request a nibble per cycle into the output register, unless the receiver stalls.
module lncs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  lncs_pkg::entry_t    q_data,
	output logic                q_rd,
	output logic                empty,
	input  logic                pop,
	output lncs_pkg::out_word_t out_word
);

	lncs_pkg::entry_t    cur_q;
	logic                busy_q;
	logic [3:0]          idx_q;
	logic                out_valid_q;
	lncs_pkg::out_word_t out_q;

	logic       adv;
	logic       emit;
	logic       is_last;
	logic       load;
	logic [4:0] step;

	assign adv     = !out_valid_q || pop;
	assign emit    = adv && busy_q;
	assign step    = lncs_pkg::step_nibble(cur_q.kind, cur_q.data, idx_q);
	assign is_last = idx_q == lncs_pkg::seq_last(cur_q.kind);
	// next request is taken in the cycle the final nibble leaves
	assign load    = q_valid && (!busy_q || (emit && is_last));
	assign q_rd    = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				busy_q <= 1'b1;
			else if (emit && is_last)
				busy_q <= 1'b0;

			if (load)
				idx_q <= '0;
			else if (emit)
				idx_q <= idx_q + 1'b1;

			if (emit)
				out_valid_q <= 1'b1;
			else if (adv)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			cur_q <= q_data;
		if (emit) begin
			out_q.rs     <= step[4];
			out_q.nibble <= step[3:0];
			out_q.last   <= is_last;
		end
	end

	assign empty    = !out_valid_q;
	assign out_word = out_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= lncs_pkg::seq_last(cur_q.kind))
		else $error("nibble index past end of request");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_q.last == $past(is_last))
		else $error("last flag does not match sequence end");

	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !is_last) |=> busy_q)
		else $error("sequencer dropped a request mid-run");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> out_valid_q)
		else $error("waiting nibble lost while stalled");

endmodule

/* design/lcd_nibble_command_sequencer.sv */
`timescale 1ns / 1ps

// LCD nibble command sequencer for a character display on a 4-bit bus.
// Input channel: push/full with in_word {op, value}. A word is taken on a
// clock edge with push high and full low. op: init, clear, character,
// two-digit number or four-digit number; codes 5..7 are taken and dropped.
// Output channel: empty/pop with out_word {rs, nibble, last}. While empty is
// low the oldest nibble write sits on out_word; pop takes it. last marks the
// final nibble of a request.
// The first nibble passes the 3-stage digit split, the queue, the sequencer
// load and the output register.
// Throughput: one nibble per cycle while the receiver pops, set by the sequencer;
// a request has init 14, clear 4, char 2, numbers 4 or 8 nibbles.
// The front takes a new word every cycle unless its last stage is held by a full 2-entry queue.
// A stalled receiver holds the output word; the sequencer and then the queue
// fill, and full rises once the front pipe cannot drain.
// Reset (arst_n low) empties the pipe, queue and output; nothing is cleared
// afterward, so the block is ready as soon as reset is released.
module lcd_nibble_command_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  lncs_pkg::in_word_t  in_word,
	output logic                empty,
	input  logic                pop,
	output lncs_pkg::out_word_t out_word
);

	// front -> queue
	logic             q_wr;
	lncs_pkg::entry_t q_wr_data;
	logic             q_full;
	// queue -> back
	logic             q_rd;
	lncs_pkg::entry_t q_rd_data;
	logic             q_nonempty;

	// classify and split numbers into BCD digits
	lncs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.q_wr      (q_wr),
		.q_wr_data (q_wr_data),
		.q_full    (q_full)
	);

	// decouples digit split from the nibble run
	lncs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_data  (q_wr_data),
		.full     (q_full),
		.rd       (q_rd),
		.rd_data  (q_rd_data),
		.nonempty (q_nonempty)
	);

	// one nibble write per cycle into the output register, unless the receiver stalls
	lncs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_nonempty),
		.q_data   (q_rd_data),
		.q_rd     (q_rd),
		.empty    (empty),
		.pop      (pop),
		.out_word (out_word)
	);

endmodule

/* sim/lcd_nibble_command_sequencer_test.sv */
`timescale 1ns / 1ps

// Request words go in on push/full; nibble writes come back on empty/pop and
// are checked one by one against a queue of predicted writes. A directed table
// comes first, then random traffic in bursts with a stalling receiver.
module lcd_nibble_command_sequencer_test;

	// op codes the block drops without output
	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	localparam int RANDOM_WORDS = 375;   // random requests that produce writes
	localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the block
	localparam int DRAIN_LIMIT  = 20000; // cycles allowed for the final drain

	// display power-up and clear sequences, command nibbles on D7..D4
	localparam logic [3:0] POWER_UP_SEQ [14] = '{
		4'h3, 4'h3, 4'h3, 4'h2,
		4'h2, 4'hC, 4'h0, 4'h8,
		4'h0, 4'h1, 4'h0, 4'h6,
		4'h0, 4'hF
	};
	localparam logic [3:0] CLEAR_SEQ [4] = '{4'h0, 4'h1, 4'h0, 4'h6};

	logic                clk;
	logic                arst_n  = 1'b0;
	logic                push    = 1'b0;
	logic                full;
	lncs_pkg::in_word_t  in_word = '0;
	logic                empty;
	logic                pop     = 1'b0;
	lncs_pkg::out_word_t out_word;

	lcd_nibble_command_sequencer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_word  (in_word),
		.empty    (empty),
		.pop      (pop),
		.out_word (out_word)
	);

	// nibble writes still owed by the block, oldest first
	lncs_pkg::out_word_t lcd_writes_due [$];

	int errors         = 0;
	int writes_checked = 0;
	int words_sent     = 0;
	int op_seen [8];
	int hold_requests  = 0; // bumped by the sender side, seen by the receiver
	bit draining       = 1'b0;

	// one row of the directed table; typed_n > 0 means the writes are typed in
	// (all with typed_rs, nibbles taken from the top of typed_nibs)
	typedef struct {
		logic [2:0]  op;
		logic [13:0] value;
		int          typed_n;
		logic        typed_rs;
		logic [31:0] typed_nibs;
	} dir_row_t;

	dir_row_t directed [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	task automatic add_row(input logic [2:0] op, input int value, input int typed_n,
			input logic typed_rs, input logic [31:0] typed_nibs);
		dir_row_t r;
		r.op         = op;
		r.value      = 14'(value);
		r.typed_n    = typed_n;
		r.typed_rs   = typed_rs;
		r.typed_nibs = typed_nibs;
		directed.push_back(r);
	endtask

	// queue the nibble writes that one request word should produce
	task automatic predict_lcd_writes(input lncs_pkg::in_word_t w);
		logic [4:0]          seq [14];
		int                  digit [4];
		int                  n_seq;
		int                  n_dig;
		int                  v;
		logic [7:0]          chr;
		lncs_pkg::out_word_t wr;
		n_seq = 0;
		n_dig = 0;
		v = int'(w.value);
		case (w.op)
			lncs_pkg::OP_INIT: begin
				for (int i = 0; i < 14; i++) begin
					seq[n_seq] = {1'b0, POWER_UP_SEQ[i]};
					n_seq++;
				end
			end
			lncs_pkg::OP_CLEAR: begin
				for (int i = 0; i < 4; i++) begin
					seq[n_seq] = {1'b0, CLEAR_SEQ[i]};
					n_seq++;
				end
			end
			lncs_pkg::OP_CHAR: begin
				// only the low byte goes out
				seq[0] = {1'b1, w.value[7:4]};
				seq[1] = {1'b1, w.value[3:0]};
				n_seq = 2;
			end
			lncs_pkg::OP_NUM2: begin
				if (v > 99)
					v = 99;
				digit[0] = v / 10;
				digit[1] = v % 10;
				n_dig = 2;
			end
			lncs_pkg::OP_NUM4: begin
				if (v > 9999)
					v = 9999;
				digit[0] = v / 1000;
				digit[1] = (v / 100) % 10;
				digit[2] = (v / 10) % 10;
				digit[3] = v % 10;
				n_dig = 4;
			end
			default: ; // spare codes: no writes
		endcase
		// digits go out as ASCII characters, high nibble first
		for (int i = 0; i < n_dig; i++) begin
			chr = 8'(48 + digit[i]);
			seq[n_seq]     = {1'b1, chr[7:4]};
			seq[n_seq + 1] = {1'b1, chr[3:0]};
			n_seq += 2;
		end
		for (int i = 0; i < n_seq; i++) begin
			wr.rs     = seq[i][4];
			wr.nibble = seq[i][3:0];
			wr.last   = (i == n_seq - 1);
			lcd_writes_due.push_back(wr);
		end
	endtask

	task automatic queue_typed_writes(input dir_row_t r);
		lncs_pkg::out_word_t wr;
		for (int i = 0; i < r.typed_n; i++) begin
			wr.rs     = r.typed_rs;
			wr.nibble = r.typed_nibs[31 - 4 * i -: 4];
			wr.last   = (i == r.typed_n - 1);
			lcd_writes_due.push_back(wr);
		end
	endtask

	// offer one word and hold it until the block takes it; push stays high on
	// return so a back-to-back word needs no second assignment in this step
	task automatic send_word(input lncs_pkg::in_word_t w);
		push    <= 1'b1;
		in_word <= w;
		do
			@(posedge clk);
		while (full);
		words_sent++;
		op_seen[w.op]++;
	endtask

	task automatic idle_sender(input int cycles);
		push <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// mostly well-formed requests; numbers mostly in range, some saturating,
	// a few spare op codes as noise
	function automatic lncs_pkg::in_word_t rand_word();
		lncs_pkg::in_word_t w;
		int                 sel;
		sel = $urandom_range(99);
		if (sel < 8)
			w.op = 3'($urandom_range(7, 5));
		else if (sel < 18)
			w.op = lncs_pkg::OP_INIT;
		else if (sel < 33)
			w.op = lncs_pkg::OP_CLEAR;
		else if (sel < 55)
			w.op = lncs_pkg::OP_CHAR;
		else if (sel < 77)
			w.op = lncs_pkg::OP_NUM2;
		else
			w.op = lncs_pkg::OP_NUM4;
		sel = $urandom_range(99);
		case (w.op)
			lncs_pkg::OP_CHAR:
				w.value = (sel < 60) ? 14'($urandom_range(255)) : 14'($urandom);
			lncs_pkg::OP_NUM2:
				w.value = (sel < 80) ? 14'($urandom_range(99)) :
					14'($urandom_range(16383, 100));
			lncs_pkg::OP_NUM4:
				w.value = (sel < 80) ? 14'($urandom_range(9999)) :
					(sel < 85) ? 14'($urandom_range(10000, 9998)) :
					14'($urandom_range(16383, 10000));
			default:
				w.value = 14'($urandom);
		endcase
		return w;
	endfunction

	task automatic check_write(input lncs_pkg::out_word_t got);
		lncs_pkg::out_word_t want;
		if (lcd_writes_due.size() == 0) begin
			$error("unexpected nibble write: rs %0d nibble %h last %0d",
				got.rs, got.nibble, got.last);
			errors++;
		end else begin
			want = lcd_writes_due.pop_front();
			writes_checked++;
			if (got.rs !== want.rs) begin
				$error("rs mismatch: expected %0d, got %0d", want.rs, got.rs);
				errors++;
			end
			if (got.nibble !== want.nibble) begin
				$error("nibble mismatch: expected %h, got %h", want.nibble, got.nibble);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last mismatch: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		end
	endtask

	// receiver: checks every popped word, stalls on segments of random mode,
	// and takes one long hold-off when the sender asks for it
	initial begin
		int seg_left;
		int mode;
		int phase;
		int hold_left;
		int holds_seen;
		seg_left   = 0;
		mode       = 0;
		phase      = 0;
		hold_left  = 0;
		holds_seen = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				check_write(out_word);
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left  = HOLD_CYCLES;
			end
			if (seg_left == 0) begin
				mode     = $urandom_range(3);
				seg_left = $urandom_range(96, 16);
			end
			seg_left--;
			phase++;
			if (draining)
				pop <= 1'b1;
			else if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (mode)
					0:       pop <= 1'b1;                       // no stalls
					1:       pop <= 1'($urandom_range(1));      // half the time
					2:       pop <= ($urandom_range(3) == 0);   // mostly stalled
					default: pop <= (phase % 3 != 0);           // fixed pattern
				endcase
			end
		end
	end

	// sender side: directed table, then random bursts
	initial begin
		lncs_pkg::in_word_t w;
		int                 useful;
		int                 burst;
		int                 gap;
		bit                 hold_done;
		bit                 pause_done;
		useful     = 0;
		hold_done  = 1'b0;
		pause_done = 1'b0;

		// init first, then typed rows: clear, byte extremes, saturated and zero numbers
		add_row(lncs_pkg::OP_INIT,  0,     0, 1'b0, 32'h0);
		add_row(lncs_pkg::OP_CLEAR, 0,     4, 1'b0, 32'h0106_0000);
		add_row(lncs_pkg::OP_CHAR,  0,     2, 1'b1, 32'h0000_0000);
		add_row(lncs_pkg::OP_CHAR,  255,   2, 1'b1, 32'hFF00_0000);
		add_row(lncs_pkg::OP_CHAR,  16383, 2, 1'b1, 32'hFF00_0000); // wide byte, low 8 bits
		add_row(lncs_pkg::OP_NUM2,  0,     4, 1'b1, 32'h3030_0000);
		add_row(lncs_pkg::OP_NUM2,  99,    4, 1'b1, 32'h3939_0000);
		add_row(lncs_pkg::OP_NUM2,  100,   4, 1'b1, 32'h3939_0000); // saturates
		add_row(lncs_pkg::OP_NUM2,  16383, 4, 1'b1, 32'h3939_0000);
		add_row(lncs_pkg::OP_NUM4,  0,     8, 1'b1, 32'h3030_3030);
		add_row(lncs_pkg::OP_NUM4,  9999,  8, 1'b1, 32'h3939_3939);
		add_row(lncs_pkg::OP_NUM4,  10000, 8, 1'b1, 32'h3939_3939); // saturates
		add_row(lncs_pkg::OP_NUM4,  16383, 8, 1'b1, 32'h3939_3939);
		// predicted rows
		add_row(lncs_pkg::OP_INIT,  16383, 0, 1'b0, 32'h0);         // value ignored
		add_row(lncs_pkg::OP_CLEAR, 10922, 0, 1'b0, 32'h0);
		add_row(OP_SPARE5,          0,     0, 1'b0, 32'h0);         // dropped codes
		add_row(OP_SPARE6,          16383, 0, 1'b0, 32'h0);
		add_row(OP_SPARE7,          5461,  0, 1'b0, 32'h0);
		add_row(lncs_pkg::OP_CHAR,  5541,  0, 1'b0, 32'h0);
		add_row(lncs_pkg::OP_CHAR,  65,    0, 1'b0, 32'h0);
		add_row(lncs_pkg::OP_NUM2,  57,    0, 1'b0, 32'h0);
		add_row(lncs_pkg::OP_NUM2,  9,     0, 1'b0, 32'h0);
		add_row(lncs_pkg::OP_NUM4,  1234,  0, 1'b0, 32'h0);
		add_row(lncs_pkg::OP_NUM4,  8075,  0, 1'b0, 32'h0);
		add_row(lncs_pkg::OP_NUM4,  10,    0, 1'b0, 32'h0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			w.op    = directed[i].op;
			w.value = directed[i].value;
			send_word(w);
			if (directed[i].typed_n > 0)
				queue_typed_writes(directed[i]);
			else
				predict_lcd_writes(w);
			if ($urandom_range(1))
				idle_sender($urandom_range(3, 1));
		end

		while (useful < RANDOM_WORDS) begin
			burst = $urandom_range(12, 1);
			repeat (burst) begin
				w = rand_word();
				send_word(w);
				predict_lcd_writes(w);
				if (w.op <= lncs_pkg::OP_NUM4)
					useful++;
				// receiver goes quiet while words keep coming: block backs up
				if (useful >= 120 && !hold_done) begin
					hold_requests++;
					hold_done = 1'b1;
				end
			end
			// one full stop: wait until every owed write is out
			if (useful >= 260 && !pause_done) begin
				idle_sender(1);
				while (lcd_writes_due.size() != 0)
					@(posedge clk);
				pause_done = 1'b1;
			end
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
			if (gap > 0)
				idle_sender(gap);
		end

		// drain with the receiver always ready, then watch for strays
		idle_sender(1);
		draining = 1'b1;
		for (int c = 0; c < DRAIN_LIMIT && lcd_writes_due.size() != 0; c++)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (lcd_writes_due.size() != 0) begin
			$error("%0d nibble writes never arrived", lcd_writes_due.size());
			errors++;
		end

		$display("%0d request words (%0d on spare codes), %0d nibble writes checked",
			words_sent, op_seen[5] + op_seen[6] + op_seen[7], writes_checked);
		$display("init %0d, clear %0d, char %0d, two-digit %0d, four-digit %0d",
			op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
